>>> hdl/bce_pkg.sv
`default_nettype none

package bce_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned PARAM_W = 17;
  localparam int unsigned DIFF_W  = COORD_W + 1;
  localparam int unsigned PROD_W  = DIFF_W + PARAM_W + 1;
  localparam int unsigned FRAC_W  = 16;

  localparam logic [PARAM_W-1:0] ONE_Q16 = PARAM_W'(65536);
  localparam logic [PARAM_W-1:0] ZERO_T  = '0;

  typedef enum logic {
    ORDER_QUAD  = 1'b0,
    ORDER_CUBIC = 1'b1
  } curve_order_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [PARAM_W-1:0] param_t;

  typedef struct packed {
    logic diff;
    logic mult;
    logic sum;
  } lerp_en_t;

endpackage

`default_nettype wire

>>> hdl/bce_if.sv
`default_nettype none

interface bce_in_if;
  logic             valid;
  logic             ready;
  logic             curve_order;
  logic [16:0]      param_t;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] ctrl_a_x;
  logic signed [31:0] ctrl_a_y;
  logic signed [31:0] ctrl_b_x;
  logic signed [31:0] ctrl_b_y;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;

  modport source (
    output valid, curve_order, param_t, start_x, start_y, ctrl_a_x, ctrl_a_y,
           ctrl_b_x, ctrl_b_y, end_x, end_y,
    input  ready
  );
  modport sink (
    input  valid, curve_order, param_t, start_x, start_y, ctrl_a_x, ctrl_a_y,
           ctrl_b_x, ctrl_b_y, end_x, end_y,
    output ready
  );
endinterface

interface bce_out_if;
  logic             valid;
  logic             ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;

  modport source (
    output valid, point_x, point_y,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/bce_lerp.sv
`default_nettype none

module bce_lerp (
  input  wire logic                clk,
  input  wire bce_pkg::lerp_en_t   en,
  input  wire bce_pkg::coord_t     a,
  input  wire bce_pkg::coord_t     b,
  input  wire bce_pkg::param_t     t,
  output bce_pkg::coord_t          y
);

  logic signed [bce_pkg::DIFF_W-1:0] d;
  bce_pkg::coord_t                   a1;
  bce_pkg::param_t                   t1;
  logic signed [bce_pkg::PROD_W-1:0] prod;
  bce_pkg::coord_t                   a2;

  // The step is a + floor(t * (b - a) / 2^16), which equals the convex form exactly.
  always_ff @(posedge clk) begin
    if (en.diff) begin
      d  <= bce_pkg::DIFF_W'(b) - bce_pkg::DIFF_W'(a);
      a1 <= a;
      t1 <= t;
    end
    if (en.mult) begin
      prod <= $signed({1'b0, t1}) * d;
      a2   <= a1;
    end
    if (en.sum) begin
      y <= a2 + prod[bce_pkg::FRAC_W + bce_pkg::COORD_W - 1:bce_pkg::FRAC_W];
    end
  end

endmodule

`default_nettype wire

>>> hdl/bezier_curve_point_evaluator.sv
// Evaluates one point of a quadratic or cubic 2D Bezier curve per transfer by
// de Casteljau interpolation in signed Q16.16 with t in unsigned Q1.16 (values
// above 1.0 saturate to 1.0). The pipeline has ten register stages: an input
// stage followed by three interpolation levels of three stages each (subtract,
// 18x33 multiply, shift and add). When the output is not stalled, one item is
// taken every cycle. Quadratic curves pass through the first level unchanged.
// A stage holds its data only while it is full and the stage after it is
// stalled, so bubbles are squeezed out and input keeps flowing while a result
// waits.
`default_nettype none

module bezier_curve_point_evaluator (
  input  wire logic  clk,
  input  wire logic  rst,
  bce_in_if.sink     req,
  bce_out_if.source  rsp
);

  localparam int unsigned NSTG = 10;

  logic [NSTG-1:0] v;
  logic [NSTG-1:0] en;

  bce_pkg::param_t t_first;
  bce_pkg::param_t ts [0:6];
  bce_pkg::coord_t px [0:3];
  bce_pkg::coord_t py [0:3];
  bce_pkg::coord_t l1x [0:2];
  bce_pkg::coord_t l1y [0:2];
  bce_pkg::coord_t l2x [0:1];
  bce_pkg::coord_t l2y [0:1];
  bce_pkg::coord_t rx;
  bce_pkg::coord_t ry;

  bce_pkg::param_t t_sat;
  logic            cubic;
  bce_pkg::coord_t p2x_next;
  bce_pkg::coord_t p2y_next;

  bce_pkg::lerp_en_t en_l1;
  bce_pkg::lerp_en_t en_l2;
  bce_pkg::lerp_en_t en_l3;

  always_comb begin
    en[NSTG-1] = !v[NSTG-1] || rsp.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign req.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= req.valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_comb begin
    t_sat    = (req.param_t > bce_pkg::ONE_Q16) ? bce_pkg::ONE_Q16 : req.param_t;
    cubic    = (bce_pkg::curve_order_t'(req.curve_order) == bce_pkg::ORDER_CUBIC);
    p2x_next = cubic ? req.ctrl_b_x : req.end_x;
    p2y_next = cubic ? req.ctrl_b_y : req.end_y;
  end

  // A quadratic item runs the first level with t at zero, which copies its points.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ts[0]   <= t_sat;
      t_first <= cubic ? t_sat : bce_pkg::ZERO_T;
      px[0]   <= req.start_x;
      py[0]   <= req.start_y;
      px[1]   <= req.ctrl_a_x;
      py[1]   <= req.ctrl_a_y;
      px[2]   <= p2x_next;
      py[2]   <= p2y_next;
      px[3]   <= req.end_x;
      py[3]   <= req.end_y;
    end
    for (int k = 1; k < 7; k++) begin
      if (en[k]) begin
        ts[k] <= ts[k-1];
      end
    end
  end

  assign en_l1 = '{diff: en[1], mult: en[2], sum: en[3]};
  assign en_l2 = '{diff: en[4], mult: en[5], sum: en[6]};
  assign en_l3 = '{diff: en[7], mult: en[8], sum: en[9]};

  for (genvar j = 0; j < 3; j++) begin : g_lvl1
    bce_lerp u_lx (.clk(clk), .en(en_l1), .a(px[j]), .b(px[j+1]), .t(t_first), .y(l1x[j]));
    bce_lerp u_ly (.clk(clk), .en(en_l1), .a(py[j]), .b(py[j+1]), .t(t_first), .y(l1y[j]));
  end

  for (genvar j = 0; j < 2; j++) begin : g_lvl2
    bce_lerp u_lx (.clk(clk), .en(en_l2), .a(l1x[j]), .b(l1x[j+1]), .t(ts[3]), .y(l2x[j]));
    bce_lerp u_ly (.clk(clk), .en(en_l2), .a(l1y[j]), .b(l1y[j+1]), .t(ts[3]), .y(l2y[j]));
  end

  bce_lerp u_l3x (.clk(clk), .en(en_l3), .a(l2x[0]), .b(l2x[1]), .t(ts[6]), .y(rx));
  bce_lerp u_l3y (.clk(clk), .en(en_l3), .a(l2y[0]), .b(l2y[1]), .t(ts[6]), .y(ry));

  assign rsp.valid   = v[NSTG-1];
  assign rsp.point_x = rx;
  assign rsp.point_y = ry;

endmodule

`default_nettype wire

>>> hdl/bce_check.sv
`default_nettype none

module bce_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [31:0] rsp_point_x,
  input wire logic [31:0] rsp_point_y
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result valid dropped before its transfer");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_point_x) && $stable(rsp_point_y))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    rsp_ready || !rsp_valid |-> req_ready)
    else $error("input stalled while the output side can move");

endmodule

bind bezier_curve_point_evaluator bce_check u_bce_check (
  .clk         (clk),
  .rst         (rst),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_point_x (rsp.point_x),
  .rsp_point_y (rsp.point_y)
);

`default_nettype wire

>>> verif/bezier_curve_point_evaluator_test.sv
`default_nettype none

module bezier_curve_point_evaluator_test;

  typedef bce_pkg::curve_order_t curve_order_t;
  typedef bce_pkg::param_t       param_t;
  typedef bce_pkg::coord_t       coord_t;

  localparam curve_order_t ORDER_QUAD  = bce_pkg::ORDER_QUAD;
  localparam curve_order_t ORDER_CUBIC = bce_pkg::ORDER_CUBIC;
  localparam param_t       ONE_Q16     = bce_pkg::ONE_Q16;
  localparam param_t       ZERO_T      = bce_pkg::ZERO_T;

  typedef struct {
    curve_order_t order;
    param_t       t;
    coord_t       sx, sy, ax, ay, bx, by, ex, ey;
  } curve_req_t;

  typedef struct {
    coord_t x;
    coord_t y;
  } curve_point_t;

  localparam coord_t MIN_C = 32'sh8000_0000;
  localparam coord_t MAX_C = 32'sh7fff_ffff;

  class curve_point_board;
    curve_point_t expected_points[$];
    int unsigned  mismatches;

    function automatic longint lerp_q16(longint a, longint b, longint t);
      return ((65536 - t) * a + t * b) >>> 16;
    endfunction

    function automatic coord_t axis_point(curve_order_t order, longint t, coord_t p0,
                                          coord_t p1, coord_t p2, coord_t p3);
      longint l0, l1, l2, m0, m1;
      if (order == ORDER_QUAD) begin
        l0 = lerp_q16(p0, p1, t);
        l1 = lerp_q16(p1, p3, t);
        return coord_t'(lerp_q16(l0, l1, t));
      end
      l0 = lerp_q16(p0, p1, t);
      l1 = lerp_q16(p1, p2, t);
      l2 = lerp_q16(p2, p3, t);
      m0 = lerp_q16(l0, l1, t);
      m1 = lerp_q16(l1, l2, t);
      return coord_t'(lerp_q16(m0, m1, t));
    endfunction

    function void note_request(curve_req_t r);
      longint       t;
      curve_point_t p;
      t = (r.t > ONE_Q16) ? 65536 : longint'(r.t);
      p.x = axis_point(r.order, t, r.sx, r.ax, r.bx, r.ex);
      p.y = axis_point(r.order, t, r.sy, r.ay, r.by, r.ey);
      expected_points.push_back(p);
    endfunction

    function void check_point(coord_t x, coord_t y);
      curve_point_t p;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point x=%h y=%h", $time, x, y);
        mismatches++;
        return;
      end
      p = expected_points.pop_front();
      if (x !== p.x) begin
        $display("%0t: point_x expected %h actual %h", $time, p.x, x);
        mismatches++;
      end
      if (y !== p.y) begin
        $display("%0t: point_y expected %h actual %h", $time, p.y, y);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_points.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   src_idle_pct;
  int   sink_stall_pct;

  curve_point_board board;

  bce_in_if  req_if ();
  bce_out_if rsp_if ();

  bezier_curve_point_evaluator u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      board.check_point(rsp_if.point_x, rsp_if.point_y);
    end
  end

  function automatic curve_req_t make_req(curve_order_t order, param_t t, coord_t sx,
                                          coord_t sy, coord_t ax, coord_t ay, coord_t bx,
                                          coord_t by, coord_t ex, coord_t ey);
    curve_req_t r;
    r.order = order;
    r.t = t;
    r.sx = sx;
    r.sy = sy;
    r.ax = ax;
    r.ay = ay;
    r.bx = bx;
    r.by = by;
    r.ex = ex;
    r.ey = ey;
    return r;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0: return MIN_C;
      1: return MAX_C;
      2: return coord_t'($urandom_range(131072) - 65536);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic param_t rand_t();
    case ($urandom_range(19))
      0: return ZERO_T;
      1: return ONE_Q16;
      2, 3, 4: return param_t'($urandom_range(131071, 65537));
      default: return param_t'($urandom_range(65536));
    endcase
  endfunction

  function automatic curve_req_t rand_req();
    curve_order_t order;
    order = curve_order_t'($urandom_range(1));
    return make_req(order, rand_t(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endfunction

  task automatic send_curve(input curve_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    req_if.valid       <= 1'b1;
    req_if.curve_order <= r.order;
    req_if.param_t     <= r.t;
    req_if.start_x     <= r.sx;
    req_if.start_y     <= r.sy;
    req_if.ctrl_a_x    <= r.ax;
    req_if.ctrl_a_y    <= r.ay;
    req_if.ctrl_b_x    <= r.bx;
    req_if.ctrl_b_y    <= r.by;
    req_if.end_x       <= r.ex;
    req_if.end_y       <= r.ey;
    do @(posedge clk); while (!req_if.ready);
    board.note_request(r);
  endtask

  // The sender holds off here until every outstanding point has come back.
  task automatic drain_points();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
  endtask

  initial begin
    board = new();
    clk = 1'b0;
    rst = 1'b1;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    req_if.valid = 1'b0;
    req_if.curve_order = 1'b0;
    req_if.param_t = '0;
    req_if.start_x = '0;
    req_if.start_y = '0;
    req_if.ctrl_a_x = '0;
    req_if.ctrl_a_y = '0;
    req_if.ctrl_b_x = '0;
    req_if.ctrl_b_y = '0;
    req_if.end_x = '0;
    req_if.end_y = '0;
    rsp_if.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle_pct = 21;
    sink_stall_pct = 21;
    send_curve(make_req(ORDER_QUAD, ZERO_T, 32'sh0001_0000, -32'sh0002_0000, 32'sh0003_8000,
                        32'sh0004_0000, MAX_C, MIN_C, -32'sh0005_0000, 32'sh0006_0000));
    send_curve(make_req(ORDER_QUAD, ONE_Q16, 32'sh0001_0000, -32'sh0002_0000, 32'sh0003_8000,
                        32'sh0004_0000, MAX_C, MIN_C, -32'sh0005_0000, 32'sh0006_0000));
    send_curve(make_req(ORDER_QUAD, 17'd65537, 32'sh1234_5678, -32'sh0abc_def0, MIN_C, MAX_C,
                        32'sh0000_0001, -32'sh0000_0001, 32'sh7654_3210, -32'sh0fed_cba9));
    send_curve(make_req(ORDER_QUAD, 17'h1ffff, MIN_C, MAX_C, MAX_C, MIN_C, MIN_C, MAX_C,
                        32'sh0000_ffff, -32'sh0001_0001));
    send_curve(make_req(ORDER_CUBIC, ZERO_T, -32'sh0010_0000, 32'sh0020_0000, 32'sh0030_0000,
                        -32'sh0040_0000, 32'sh0050_0000, 32'sh0060_0000, MAX_C, MIN_C));
    send_curve(make_req(ORDER_CUBIC, ONE_Q16, -32'sh0010_0000, 32'sh0020_0000, 32'sh0030_0000,
                        -32'sh0040_0000, 32'sh0050_0000, 32'sh0060_0000, MAX_C, MIN_C));
    send_curve(make_req(ORDER_CUBIC, 17'h1ffff, MAX_C, MIN_C, 32'sh0000_0100, -32'sh0000_0100,
                        MIN_C, MAX_C, -32'sh0777_0000, 32'sh0333_0000));
    send_curve(make_req(ORDER_CUBIC, 17'd65537, MAX_C, MIN_C, 32'sh0000_0100, -32'sh0000_0100,
                        MIN_C, MAX_C, -32'sh0777_0000, 32'sh0333_0000));
    send_curve(make_req(ORDER_CUBIC, 17'd1, MIN_C, MAX_C, MAX_C, MIN_C, MIN_C, MAX_C,
                        MAX_C, MIN_C));
    send_curve(make_req(ORDER_CUBIC, 17'd65535, MIN_C, MAX_C, MAX_C, MIN_C, MIN_C, MAX_C,
                        MAX_C, MIN_C));
    send_curve(make_req(ORDER_CUBIC, 17'd32768, MIN_C, MAX_C, MAX_C, MIN_C, MIN_C, MAX_C,
                        MAX_C, MIN_C));
    send_curve(make_req(ORDER_QUAD, 17'd32768, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C,
                        MAX_C, MAX_C));
    send_curve(make_req(ORDER_QUAD, 17'd32768, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C,
                        MIN_C, MIN_C));
    send_curve(make_req(ORDER_CUBIC, 17'd12345, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C,
                        MAX_C, MAX_C));
    send_curve(make_req(ORDER_CUBIC, 17'd54321, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C,
                        MIN_C, MIN_C));
    send_curve(make_req(ORDER_QUAD, 17'd32767, MIN_C, MAX_C, MAX_C, MIN_C, MIN_C, MAX_C,
                        MIN_C, MAX_C));
    send_curve(make_req(ORDER_QUAD, 17'd40000, 32'sh0000_1000, 32'sh0000_2000, 32'sh0000_3000,
                        32'sh0000_4000, MIN_C, MAX_C, 32'sh0000_5000, 32'sh0000_6000));
    send_curve(make_req(ORDER_QUAD, 17'd40000, 32'sh0000_1000, 32'sh0000_2000, 32'sh0000_3000,
                        32'sh0000_4000, MAX_C, MIN_C, 32'sh0000_5000, 32'sh0000_6000));
    send_curve(make_req(ORDER_CUBIC, 17'd32768, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
                        -32'sd1, -32'sd1, -32'sd1));
    send_curve(make_req(ORDER_CUBIC, 17'd3, -32'sd1, 32'sd1, 32'sd1, -32'sd1, -32'sd1,
                        32'sd1, 32'sd1, -32'sd1));
    send_curve(make_req(ORDER_CUBIC, ZERO_T, '0, '0, '0, '0, '0, '0, '0, '0));
    send_curve(make_req(ORDER_QUAD, 17'd21845, 32'sh5555_5555, 32'shaaaa_aaaa,
                        32'shaaaa_aaaa, 32'sh5555_5555, 32'sh5555_5555, 32'shaaaa_aaaa,
                        32'sh5555_5555, 32'shaaaa_aaaa));
    drain_points();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 61;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 61;
        end
        default: begin
          src_idle_pct = 21;
          sink_stall_pct = 21;
        end
      endcase
      repeat (425) send_curve(rand_req());
      drain_points();
    end

    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("bezier_curve_point_evaluator regression: pass");
    end else begin
      $display("bezier_curve_point_evaluator regression: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("bezier_curve_point_evaluator regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
